@@ design/wedg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedg_pkg
// Shared constants, codes and types of the window edge density grid.
// ----------------------------------------------------------------------------
package wedg_pkg;

    // grid and counter geometry
    localparam int MAX_COLS    = 8;
    localparam int MAX_ROWS    = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int CELLS       = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COLS_W      = $clog2(MAX_COLS + 1);
    localparam int ROWS_W      = $clog2(MAX_ROWS + 1);

    // field widths
    localparam int OP_W        = 3;
    localparam int PIX_W       = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_OUT_W   = 16;
    localparam int STATUS_W    = 2;

    // shared divider
    localparam int DIV_W       = 13;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BOUNDS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;

    // configuration reset values
    localparam int IMAGE_WIDTH_RST   = 640;
    localparam int IMAGE_HEIGHT_RST  = 480;
    localparam int WINDOW_WIDTH_RST  = 80;
    localparam int WINDOW_HEIGHT_RST = 60;
    localparam int COLS_RST = (IMAGE_WIDTH_RST / WINDOW_WIDTH_RST > MAX_COLS) ?
                              MAX_COLS : IMAGE_WIDTH_RST / WINDOW_WIDTH_RST;
    localparam int ROWS_RST = (IMAGE_HEIGHT_RST / WINDOW_HEIGHT_RST > MAX_ROWS) ?
                              MAX_ROWS : IMAGE_HEIGHT_RST / WINDOW_HEIGHT_RST;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ design/wedg_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedg_req_if
// Operation request channel: operation code and pixel point.
// ----------------------------------------------------------------------------
interface wedg_req_if;
    logic                        valid;
    logic                        ready;
    logic [wedg_pkg::OP_W-1:0]   operation;
    logic [wedg_pkg::PIX_W-1:0]  pixel_x;
    logic [wedg_pkg::PIX_W-1:0]  pixel_y;

    modport source (output valid, output operation, output pixel_x, output pixel_y,
                    input ready);
    modport sink   (input valid, input operation, input pixel_x, input pixel_y,
                    output ready);
endinterface

@@ design/wedg_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedg_rsp_if
// Result channel: count, empty window corner, status and last flag.
// ----------------------------------------------------------------------------
interface wedg_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wedg_pkg::CNT_OUT_W-1:0] count;
    logic [wedg_pkg::PIX_W-1:0]           corner_x;
    logic [wedg_pkg::PIX_W-1:0]           corner_y;
    logic [wedg_pkg::STATUS_W-1:0]        status;
    logic                                 last;

    modport source (output valid, output count, output corner_x, output corner_y,
                    output status, output last, input ready);
    modport sink   (input valid, input count, input corner_x, input corner_y,
                    input status, input last, output ready);
endinterface

@@ design/wedg_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wedg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wedg_pkg::CFG_IDX_W-1:0]   index;
    logic [wedg_pkg::CFG_W-1:0]       wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ design/wedg_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedg_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module wedg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  wedg_pkg::div_req_t req,
    output wedg_pkg::div_rsp_t rsp
);

    logic [wedg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           done_reg;
    logic [wedg_pkg::DIV_W:0]       rem_reg;
    logic [wedg_pkg::DIV_W-1:0]     quo_reg;
    logic [wedg_pkg::DIV_W-1:0]     dvs_reg;

    logic [wedg_pkg::DIV_W:0]       shifted;
    logic [wedg_pkg::DIV_W+1:0]     diff;

    // trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shifted = {rem_reg[wedg_pkg::DIV_W-1:0], quo_reg[wedg_pkg::DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= wedg_pkg::DIV_CNT_W'(wedg_pkg::DIV_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == wedg_pkg::DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[wedg_pkg::DIV_W+1])
            begin
                rem_reg <= diff[wedg_pkg::DIV_W:0];
                quo_reg <= {quo_reg[wedg_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[wedg_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ design/window_edge_density_grid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_edge_density_grid
// Grid of saturating window counters with add, remove, query, scan and clear.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; req.ready is high only while the
// sequencer is idle, and the next request may be taken while the last result
// still waits in the output register. Operation time is set by the single
// shared restoring divider and by the counter memory with one write port and
// one registered read port. Add or remove of a point in the image divides for
// its window, then steps through the nine neighbor windows, reading and
// writing back each one inside the grid and skipping the rest. Query divides
// for its window and reads it when it lies inside the grid. Clear, unknown
// codes and points off the image go straight to the result. Scan reads every
// grid window and emits one result per empty window, or a single no-empty
// result. A result that waits for a full output register stalls the
// sequencer. After a write to any of the four configuration registers the
// next add, remove or query of a point in the image, or the next scan, first
// derives the grid size by two divisions. Configuration writes are always
// accepted. Clear takes effect at once through per-window valid bits; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module window_edge_density_grid (
    input  logic         clk,
    input  logic         rst_n,
    wedg_req_if.sink     req,
    wedg_rsp_if.source   rsp,
    wedg_cfg_if.sink     cfg
);

    localparam int CW    = wedg_pkg::COUNT_WIDTH;
    localparam int PW    = wedg_pkg::PIX_W;
    localparam int DW    = wedg_pkg::DIV_W;
    localparam int AW    = wedg_pkg::ADDR_W;
    localparam int CLW   = wedg_pkg::COLS_W;
    localparam int RWW   = wedg_pkg::ROWS_W;

    localparam logic [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_DIV_GO   = 4'd2;
    localparam logic [3:0] S_DIV_WAIT = 4'd3;
    localparam logic [3:0] S_ADJ_SEL  = 4'd4;
    localparam logic [3:0] S_ADJ_MOD  = 4'd5;
    localparam logic [3:0] S_Q_CHK    = 4'd6;
    localparam logic [3:0] S_Q_DAT    = 4'd7;
    localparam logic [3:0] S_SC_INIT  = 4'd8;
    localparam logic [3:0] S_SC_RD    = 4'd9;
    localparam logic [3:0] S_SC_CHK   = 4'd10;
    localparam logic [3:0] S_SC_END   = 4'd11;
    localparam logic [3:0] S_EMIT     = 4'd12;

    // divider jobs
    localparam logic [1:0] DSEL_COLS = 2'd0;
    localparam logic [1:0] DSEL_ROWS = 2'd1;
    localparam logic [1:0] DSEL_X    = 2'd2;
    localparam logic [1:0] DSEL_Y    = 2'd3;

    localparam logic [1:0] NB_LAST   = 2'd2;

    typedef struct packed {
        logic [wedg_pkg::CNT_OUT_W-1:0] count;
        logic [PW-1:0]                  corner_x;
        logic [PW-1:0]                  corner_y;
        logic [wedg_pkg::STATUS_W-1:0]  status;
        logic                           last;
    } result_t;

    // control registers
    logic [3:0]       state_reg, state_next;
    logic [3:0]       ret_reg, ret_next;
    logic [1:0]       dsel_reg, dsel_next;
    logic             dirty_reg, dirty_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [CLW-1:0]   cols_reg, cols_next;
    logic [RWW-1:0]   rows_reg, rows_next;
    logic [wedg_pkg::CFG_W-1:0] iw_reg, iw_next;
    logic [wedg_pkg::CFG_W-1:0] ih_reg, ih_next;
    logic [wedg_pkg::CFG_W-1:0] ww_reg, ww_next;
    logic [wedg_pkg::CFG_W-1:0] wh_reg, wh_next;
    logic [wedg_pkg::CELLS-1:0] vld_reg;
    logic             rd_vld_reg;

    // payload registers
    logic [wedg_pkg::OP_W-1:0] op_reg, op_next;
    logic [PW-1:0]    px_reg, px_next;
    logic [PW-1:0]    py_reg, py_next;
    logic [PW-1:0]    wx_reg, wx_next;
    logic [PW-1:0]    wy_reg, wy_next;
    logic [1:0]       nbx_reg, nbx_next;
    logic [1:0]       nby_reg, nby_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [CLW-1:0]   sx_reg, sx_next;
    logic [RWW-1:0]   sy_reg, sy_next;
    logic [DW-1:0]    cx_reg, cx_next;
    logic [DW-1:0]    cy_reg, cy_next;
    logic [DW-1:0]    pcx_reg, pcx_next;
    logic [DW-1:0]    pcy_reg, pcy_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    logic [CW-1:0]    rd_data_reg;

    // counter memory
    logic [CW-1:0]    cnt_mem [wedg_pkg::CELLS];
    logic             mem_re, mem_we, clr_all;
    logic [AW-1:0]    mem_raddr;
    logic [CW-1:0]    mem_wdata;

    // divider
    wedg_pkg::div_req_t div_req;
    wedg_pkg::div_rsp_t div_rsp;

    // datapath helpers
    logic [DW-1:0]    win_w, win_h;
    logic             in_image, out_free;
    logic signed [CW-1:0] cur_cnt;
    logic signed [31:0]   cur_ext;
    logic [CW-1:0]    sat_cnt;
    logic [PW:0]      adj_tx, adj_ty;
    logic             adj_in, adj_adv, nb_last;
    logic [AW-1:0]    adj_addr, scan_addr;
    logic             sx_end, sy_end;

    wedg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // zero window size acts as one pixel
    assign win_w    = (ww_reg == '0) ? DW'(1) : ww_reg;
    assign win_h    = (wh_reg == '0) ? DW'(1) : wh_reg;
    assign in_image = ({1'b0, px_reg} < iw_reg) && ({1'b0, py_reg} < ih_reg);

    // counter read value, never-written or cleared windows read as zero
    assign cur_cnt = rd_vld_reg ? rd_data_reg : '0;
    assign cur_ext = 32'(cur_cnt);

    // saturating increment or decrement
    always_comb
    begin
        if (op_reg == wedg_pkg::OP_ADD)
        begin
            sat_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
        end
        else
        begin
            sat_cnt = (cur_cnt == CNT_MIN) ? cur_cnt : cur_cnt - 1'b1;
        end
    end

    // neighbor window position, offset by one so that -1 maps to zero
    assign adj_tx   = {1'b0, wx_reg} + (PW+1)'(nbx_reg);
    assign adj_ty   = {1'b0, wy_reg} + (PW+1)'(nby_reg);
    assign adj_in   = (adj_tx != '0) && (adj_tx <= (PW+1)'(cols_reg)) &&
                      (adj_ty != '0) && (adj_ty <= (PW+1)'(rows_reg));
    assign adj_addr = AW'((adj_ty - 1'b1) * wedg_pkg::MAX_COLS + (adj_tx - 1'b1));
    assign nb_last  = (nbx_reg == NB_LAST) && (nby_reg == NB_LAST);
    assign adj_adv  = ((state_reg == S_ADJ_SEL) && !adj_in) || (state_reg == S_ADJ_MOD);

    // scan position
    assign scan_addr = AW'(sy_reg * wedg_pkg::MAX_COLS + sx_reg);
    assign sx_end    = ((sx_reg + 1'b1) == cols_reg);
    assign sy_end    = ((sy_reg + 1'b1) == rows_reg);

    assign out_free  = !out_valid_reg || rsp.ready;

    // divider operand selection
    always_comb
    begin
        div_req.start = (state_reg == S_DIV_GO);
        unique case (dsel_reg)
            DSEL_COLS:
            begin
                div_req.dividend = iw_reg;
                div_req.divisor  = win_w;
            end
            DSEL_ROWS:
            begin
                div_req.dividend = ih_reg;
                div_req.divisor  = win_h;
            end
            DSEL_X:
            begin
                div_req.dividend = {1'b0, px_reg};
                div_req.divisor  = win_w;
            end
            default:
            begin
                div_req.dividend = {1'b0, py_reg};
                div_req.divisor  = win_h;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        dsel_next      = dsel_reg;
        dirty_next     = dirty_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        iw_next        = iw_reg;
        ih_next        = ih_reg;
        ww_next        = ww_reg;
        wh_next        = wh_reg;
        op_next        = op_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        nbx_next       = nbx_reg;
        nby_next       = nby_reg;
        addr_next      = addr_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        pcx_next       = pcx_reg;
        pcy_next       = pcy_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mem_re         = 1'b0;
        mem_raddr      = scan_addr;
        mem_we         = 1'b0;
        mem_wdata      = sat_cnt;
        clr_all        = 1'b0;

        // result register drains on transfer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg.valid)
        begin
            unique case (cfg.index)
                wedg_pkg::REG_IMAGE_WIDTH:
                begin
                    iw_next    = cfg.wdata;
                    dirty_next = 1'b1;
                end
                wedg_pkg::REG_IMAGE_HEIGHT:
                begin
                    ih_next    = cfg.wdata;
                    dirty_next = 1'b1;
                end
                wedg_pkg::REG_WINDOW_WIDTH:
                begin
                    ww_next    = cfg.wdata;
                    dirty_next = 1'b1;
                end
                wedg_pkg::REG_WINDOW_HEIGHT:
                begin
                    wh_next    = cfg.wdata;
                    dirty_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    px_next    = req.pixel_x;
                    py_next    = req.pixel_y;
                    state_next = S_START;
                end
            end

            // dispatch on the operation code
            S_START:
            begin
                res_next  = '{count: '0, corner_x: '0, corner_y: '0,
                              status: wedg_pkg::ST_OK, last: 1'b1};
                ret_next  = S_IDLE;
                dsel_next = dirty_reg ? DSEL_COLS : DSEL_X;
                unique case (op_reg)
                    wedg_pkg::OP_ADD, wedg_pkg::OP_REMOVE, wedg_pkg::OP_QUERY:
                    begin
                        if (!in_image)
                        begin
                            res_next.status = wedg_pkg::ST_BOUNDS;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_DIV_GO;
                        end
                    end
                    wedg_pkg::OP_SCAN:
                    begin
                        state_next = dirty_reg ? S_DIV_GO : S_SC_INIT;
                    end
                    wedg_pkg::OP_CLEAR:
                    begin
                        clr_all    = 1'b1;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end

            // collect quotient and chain the next division
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    unique case (dsel_reg)
                        DSEL_COLS:
                        begin
                            cols_next  = (div_rsp.quotient > DW'(wedg_pkg::MAX_COLS)) ?
                                         CLW'(wedg_pkg::MAX_COLS) :
                                         div_rsp.quotient[CLW-1:0];
                            dsel_next  = DSEL_ROWS;
                            state_next = S_DIV_GO;
                        end
                        DSEL_ROWS:
                        begin
                            rows_next  = (div_rsp.quotient > DW'(wedg_pkg::MAX_ROWS)) ?
                                         RWW'(wedg_pkg::MAX_ROWS) :
                                         div_rsp.quotient[RWW-1:0];
                            dirty_next = 1'b0;
                            dsel_next  = DSEL_X;
                            state_next = (op_reg == wedg_pkg::OP_SCAN) ? S_SC_INIT : S_DIV_GO;
                        end
                        DSEL_X:
                        begin
                            wx_next    = div_rsp.quotient[PW-1:0];
                            dsel_next  = DSEL_Y;
                            state_next = S_DIV_GO;
                        end
                        default:
                        begin
                            wy_next    = div_rsp.quotient[PW-1:0];
                            nbx_next   = '0;
                            nby_next   = '0;
                            state_next = (op_reg == wedg_pkg::OP_QUERY) ? S_Q_CHK : S_ADJ_SEL;
                        end
                    endcase
                end
            end

            // read a neighbor inside the grid
            S_ADJ_SEL:
            begin
                if (adj_in)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = adj_addr;
                    addr_next  = adj_addr;
                    state_next = S_ADJ_MOD;
                end
            end

            // write back the adjusted counter
            S_ADJ_MOD:
            begin
                mem_we = 1'b1;
            end

            S_Q_CHK:
            begin
                if (({1'b0, wx_reg} < (PW+1)'(cols_reg)) &&
                    ({1'b0, wy_reg} < (PW+1)'(rows_reg)))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(wy_reg * wedg_pkg::MAX_COLS + wx_reg);
                    state_next = S_Q_DAT;
                end
                else
                begin
                    res_next.status = wedg_pkg::ST_BOUNDS;
                    state_next      = S_EMIT;
                end
            end

            S_Q_DAT:
            begin
                res_next.count = cur_ext[wedg_pkg::CNT_OUT_W-1:0];
                state_next     = S_EMIT;
            end

            S_SC_INIT:
            begin
                sx_next   = '0;
                sy_next   = '0;
                cx_next   = '0;
                cy_next   = '0;
                pend_next = 1'b0;
                if ((cols_reg == '0) || (rows_reg == '0))
                begin
                    res_next.status = wedg_pkg::ST_NO_EMPTY;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_SC_RD;
                end
            end

            S_SC_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SC_CHK;
            end

            // test one window, hold back one empty corner to mark the last
            S_SC_CHK:
            begin
                if (sx_end)
                begin
                    sx_next = '0;
                    cx_next = '0;
                    sy_next = sy_reg + 1'b1;
                    cy_next = cy_reg + win_h;
                end
                else
                begin
                    sx_next = sx_reg + 1'b1;
                    cx_next = cx_reg + win_w;
                end
                state_next = (sx_end && sy_end) ? S_SC_END : S_SC_RD;
                if (cur_cnt == '0)
                begin
                    pend_next = 1'b1;
                    pcx_next  = cx_reg;
                    pcy_next  = cy_reg;
                    if (pend_reg)
                    begin
                        res_next.corner_x = pcx_reg[PW-1:0];
                        res_next.corner_y = pcy_reg[PW-1:0];
                        res_next.last     = 1'b0;
                        ret_next          = (sx_end && sy_end) ? S_SC_END : S_SC_RD;
                        state_next        = S_EMIT;
                    end
                end
            end

            S_SC_END:
            begin
                ret_next   = S_IDLE;
                state_next = S_EMIT;
                res_next.last = 1'b1;
                if (pend_reg)
                begin
                    res_next.corner_x = pcx_reg[PW-1:0];
                    res_next.corner_y = pcy_reg[PW-1:0];
                    res_next.status   = wedg_pkg::ST_OK;
                end
                else
                begin
                    res_next.corner_x = '0;
                    res_next.corner_y = '0;
                    res_next.status   = wedg_pkg::ST_NO_EMPTY;
                end
            end

            // hand the result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next of the nine neighbors
        if (adj_adv)
        begin
            if (nb_last)
            begin
                ret_next   = S_IDLE;
                state_next = S_EMIT;
            end
            else
            begin
                state_next = S_ADJ_SEL;
                if (nbx_reg == NB_LAST)
                begin
                    nbx_next = '0;
                    nby_next = nby_reg + 1'b1;
                end
                else
                begin
                    nbx_next = nbx_reg + 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            dsel_reg      <= DSEL_COLS;
            dirty_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cols_reg      <= CLW'(wedg_pkg::COLS_RST);
            rows_reg      <= RWW'(wedg_pkg::ROWS_RST);
            iw_reg        <= wedg_pkg::CFG_W'(wedg_pkg::IMAGE_WIDTH_RST);
            ih_reg        <= wedg_pkg::CFG_W'(wedg_pkg::IMAGE_HEIGHT_RST);
            ww_reg        <= wedg_pkg::CFG_W'(wedg_pkg::WINDOW_WIDTH_RST);
            wh_reg        <= wedg_pkg::CFG_W'(wedg_pkg::WINDOW_HEIGHT_RST);
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            dsel_reg      <= dsel_next;
            dirty_reg     <= dirty_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            iw_reg        <= iw_next;
            ih_reg        <= ih_next;
            ww_reg        <= ww_next;
            wh_reg        <= wh_next;
        end
    end

    // per-window valid bits, cleared by reset and by the clear operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr_all)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_vld_reg <= vld_reg[mem_raddr];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        wx_reg   <= wx_next;
        wy_reg   <= wy_next;
        nbx_reg  <= nbx_next;
        nby_reg  <= nby_next;
        addr_reg <= addr_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        pcx_reg  <= pcx_next;
        pcy_reg  <= pcy_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // counter memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[addr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cnt_mem[mem_raddr];
        end
    end

    // ports
    assign req.ready    = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign rsp.valid    = out_valid_reg;
    assign rsp.count    = out_reg.count;
    assign rsp.corner_x = out_reg.corner_x;
    assign rsp.corner_y = out_reg.corner_y;
    assign rsp.status   = out_reg.status;
    assign rsp.last     = out_reg.last;

endmodule

@@ tb/wedg_grid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedg_grid_checker
// Watches the request, result and configuration channels of the window edge
// density grid. It keeps its own copy of the window counters and of the
// geometry registers. It works out the results of each accepted request and
// compares every result transfer, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module wedg_grid_checker
    import wedg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    wedg_req_if  req,
    wedg_rsp_if  rsp,
    wedg_cfg_if  cfg,
    output int   fail_count,
    output int   results_due,
    output int   results_checked
);

    localparam longint COUNT_MAX  = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
    localparam longint COUNT_MIN  = -COUNT_MAX - 1;

    typedef struct packed {
        logic signed [CNT_OUT_W-1:0] count;
        logic [PIX_W-1:0]            corner_x;
        logic [PIX_W-1:0]            corner_y;
        logic [STATUS_W-1:0]         status;
        logic                        last;
    } grid_result_t;

    // shadow geometry registers and window counters
    logic [CFG_W-1:0] image_w;
    logic [CFG_W-1:0] image_h;
    logic [CFG_W-1:0] win_w_raw;
    logic [CFG_W-1:0] win_h_raw;
    longint           window_count [CELLS];

    grid_result_t     grid_results_queue [$];
    int               mismatches;
    int               checked;

    // zero window size acts as one pixel
    function automatic int win_w_eff();
        return (win_w_raw == '0) ? 1 : int'(win_w_raw);
    endfunction

    function automatic int win_h_eff();
        return (win_h_raw == '0) ? 1 : int'(win_h_raw);
    endfunction

    function automatic int grid_cols_now();
        int c;
        c = int'(image_w) / win_w_eff();
        return (c > MAX_COLS) ? MAX_COLS : c;
    endfunction

    function automatic int grid_rows_now();
        int r;
        r = int'(image_h) / win_h_eff();
        return (r > MAX_ROWS) ? MAX_ROWS : r;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $time, checked, field, got, want);
        mismatches++;
    endtask

    task automatic queue_result(input longint cnt, input int cx, input int cy,
                                input logic [STATUS_W-1:0] st, input logic lst);
        grid_result_t r;
        r.count    = cnt[CNT_OUT_W-1:0];
        r.corner_x = cx[PIX_W-1:0];
        r.corner_y = cy[PIX_W-1:0];
        r.status   = st;
        r.last     = lst;
        grid_results_queue = {grid_results_queue, r};
    endtask

    // saturating step of a window and its in-grid neighbors
    task automatic bump_neighborhood(input int wx, input int wy, input bit raise);
        int cols;
        int rows;
        int x;
        int y;
        int idx;
        cols = grid_cols_now();
        rows = grid_rows_now();
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                x = wx + dx;
                y = wy + dy;
                if (x >= 0 && x < cols && y >= 0 && y < rows)
                begin
                    idx = y * MAX_COLS + x;
                    if (raise && window_count[idx] < COUNT_MAX)
                        window_count[idx] = window_count[idx] + 1;
                    else if (!raise && window_count[idx] > COUNT_MIN)
                        window_count[idx] = window_count[idx] - 1;
                end
            end
        end
    endtask

    // update the grid for one request and queue the results it causes
    task automatic predict_grid_op(input logic [OP_W-1:0] op,
                                   input logic [PIX_W-1:0] px,
                                   input logic [PIX_W-1:0] py);
        bit     in_image;
        int     wx;
        int     wy;
        int     cols;
        int     rows;
        int     empties;
        int     k;
        longint value;
        in_image = (int'(px) < int'(image_w)) && (int'(py) < int'(image_h));
        wx       = int'(px) / win_w_eff();
        wy       = int'(py) / win_h_eff();
        cols     = grid_cols_now();
        rows     = grid_rows_now();
        case (op)
            OP_ADD, OP_REMOVE:
            begin
                if (!in_image)
                    queue_result(0, 0, 0, ST_BOUNDS, 1'b1);
                else
                begin
                    bump_neighborhood(wx, wy, op == OP_ADD);
                    queue_result(0, 0, 0, ST_OK, 1'b1);
                end
            end
            OP_QUERY:
            begin
                if (!in_image || wx >= cols || wy >= rows)
                    queue_result(0, 0, 0, ST_BOUNDS, 1'b1);
                else
                begin
                    value = window_count[wy * MAX_COLS + wx];
                    queue_result(value, 0, 0, ST_OK, 1'b1);
                end
            end
            OP_SCAN:
            begin
                empties = 0;
                for (int y = 0; y < rows; y++)
                    for (int x = 0; x < cols; x++)
                        if (window_count[y * MAX_COLS + x] == 0)
                            empties++;
                if (empties == 0)
                    queue_result(0, 0, 0, ST_NO_EMPTY, 1'b1);
                else
                begin
                    k = 0;
                    for (int y = 0; y < rows; y++)
                    begin
                        for (int x = 0; x < cols; x++)
                        begin
                            if (window_count[y * MAX_COLS + x] == 0)
                            begin
                                k++;
                                queue_result(0, x * win_w_eff(), y * win_h_eff(),
                                             ST_OK, k == empties);
                            end
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                foreach (window_count[i])
                    window_count[i] = 0;
                queue_result(0, 0, 0, ST_OK, 1'b1);
            end
            default:
                queue_result(0, 0, 0, ST_OK, 1'b1);
        endcase
    endtask

    task automatic compare_result();
        grid_result_t want;
        if (grid_results_queue.size() == 0)
        begin
            report_mismatch("results outstanding", 0, 1);
        end
        else
        begin
            want = grid_results_queue.pop_front();
            if (rsp.count !== want.count)
                report_mismatch("count", longint'(rsp.count), longint'(want.count));
            if (rsp.corner_x !== want.corner_x)
                report_mismatch("corner_x", rsp.corner_x, want.corner_x);
            if (rsp.corner_y !== want.corner_y)
                report_mismatch("corner_y", rsp.corner_y, want.corner_y);
            if (rsp.status !== want.status)
                report_mismatch("status", rsp.status, want.status);
            if (rsp.last !== want.last)
                report_mismatch("last", rsp.last, want.last);
        end
        checked++;
    endtask

    // watch all three channels; results are checked before new ones are queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_w   = CFG_W'(IMAGE_WIDTH_RST);
            image_h   = CFG_W'(IMAGE_HEIGHT_RST);
            win_w_raw = CFG_W'(WINDOW_WIDTH_RST);
            win_h_raw = CFG_W'(WINDOW_HEIGHT_RST);
            foreach (window_count[i])
                window_count[i] = 0;
            grid_results_queue.delete();
            mismatches = 0;
            checked    = 0;
            fail_count      <= 0;
            results_due     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                compare_result();
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                case (cfg.index)
                    REG_IMAGE_WIDTH:   image_w   = cfg.wdata;
                    REG_IMAGE_HEIGHT:  image_h   = cfg.wdata;
                    REG_WINDOW_WIDTH:  win_w_raw = cfg.wdata;
                    REG_WINDOW_HEIGHT: win_h_raw = cfg.wdata;
                    default: ;
                endcase
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                predict_grid_op(req.operation, req.pixel_x, req.pixel_y);
            fail_count      <= mismatches;
            results_due     <= grid_results_queue.size();
            results_checked <= checked;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the window edge density grid. Runs directed and
// random add, remove, query, scan and clear requests over several grid
// geometries, with random idle bursts on both channels; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import wedg_pkg::*;

    localparam int              CYCLE_LIMIT   = 1000000;
    localparam int              SETTLE_CYCLES = 64;
    localparam int              PIX_MAX       = (1 << PIX_W) - 1;
    localparam logic [OP_W-1:0] OP_TOP_CODE   = '1;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_enable;
    int   fail_count;
    int   results_due;
    int   results_checked;
    int   ops_sent;
    int   setups;
    int   cycle_count = 0;

    wedg_req_if req_ch ();
    wedg_rsp_if rsp_ch ();
    wedg_cfg_if cfg_ch ();

    window_edge_density_grid dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    wedg_grid_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg             (cfg_ch),
        .fail_count      (fail_count),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: ready with random stall bursts
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // one request transfer, sometimes after an idle burst
    task automatic issue_op(input logic [OP_W-1:0] op, input int px, input int py);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.pixel_x   <= px[PIX_W-1:0];
        req_ch.pixel_y   <= py[PIX_W-1:0];
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        ops_sent++;
    endtask

    // stop sending until every outstanding result has come back
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // valid stays high across back-to-back writes; the caller lowers it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value[CFG_W-1:0];
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
    endtask

    // new grid geometry, written only while the block is idle
    task automatic apply_geometry(input int img_w, input int img_h,
                                  input int win_w, input int win_h);
        wait_for_results();
        write_register(REG_IMAGE_WIDTH, img_w);
        write_register(REG_IMAGE_HEIGHT, img_h);
        write_register(REG_WINDOW_WIDTH, win_w);
        write_register(REG_WINDOW_HEIGHT, win_h);
        cfg_ch.valid <= 1'b0;
        setups++;
    endtask

    // random requests; most points land near the grid, some anywhere
    task automatic send_random_ops(input int n, input int x_span, input int y_span);
        int              pick;
        int              px;
        int              py;
        logic [OP_W-1:0] op;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = OP_ADD;
            else if (pick < 58)
                op = OP_REMOVE;
            else if (pick < 82)
                op = OP_QUERY;
            else if (pick < 92)
                op = OP_SCAN;
            else if (pick < 96)
                op = OP_CLEAR;
            else
                op = OP_W'($urandom_range(OP_CLEAR + 1, OP_TOP_CODE));
            if ($urandom_range(0, 6) == 0)
            begin
                px = $urandom_range(0, PIX_MAX);
                py = $urandom_range(0, PIX_MAX);
            end
            else
            begin
                px = $urandom_range(0, x_span);
                py = $urandom_range(0, y_span);
            end
            issue_op(op, px, py);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        idle_enable      = 1'b1;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ADD;
        req_ch.pixel_x   = '0;
        req_ch.pixel_y   = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_IMAGE_WIDTH;
        cfg_ch.wdata     = '0;
        ops_sent         = 0;
        setups           = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default 8x8 grid of 80x60 windows: empty grid, corners, off-image points
        issue_op(OP_QUERY, 0, 0);
        issue_op(OP_SCAN, 0, 0);
        issue_op(OP_ADD, 0, 0);
        issue_op(OP_ADD, 639, 479);
        issue_op(OP_ADD, PIX_MAX, PIX_MAX);
        issue_op(OP_REMOVE, 640, 0);
        issue_op(OP_QUERY, 0, 480);
        issue_op(OP_REMOVE, 80, 60);
        issue_op(OP_QUERY, 80, 60);
        issue_op(OP_QUERY, 639, 479);
        issue_op(OP_SCAN, 0, 0);
        issue_op(OP_W'(OP_CLEAR + 1), PIX_MAX, 0);
        issue_op(OP_TOP_CODE, 0, PIX_MAX);
        issue_op(OP_CLEAR, 0, 0);

        // cover every window so the scan finds none empty
        for (int gy = 1; gy < 8; gy += 3)
            for (int gx = 1; gx < 8; gx += 3)
                issue_op(OP_ADD, gx * 80 + 5, gy * 60 + 3);
        issue_op(OP_SCAN, 0, 0);

        send_random_ops(15, 700, 520);
        wait_for_results();
        send_random_ops(15, 700, 520);

        // one-pixel-wide windows, single row, every point inside the image
        apply_geometry(8191, 4096, 0, 4096);
        issue_op(OP_QUERY, 7, 0);
        issue_op(OP_QUERY, 8, 0);
        issue_op(OP_ADD, PIX_MAX, PIX_MAX);
        send_random_ops(30, 12, 2);

        // windows larger than the image: no grid at all
        apply_geometry(1, 1, 8191, 4096);
        issue_op(OP_ADD, 0, 0);
        issue_op(OP_QUERY, 0, 0);
        issue_op(OP_SCAN, 0, 0);
        issue_op(OP_REMOVE, 1, 0);
        send_random_ops(10, 3, 3);

        // partial windows at the right and bottom edges
        apply_geometry(100, 70, 30, 20);
        issue_op(OP_ADD, 99, 69);
        issue_op(OP_QUERY, 95, 65);
        issue_op(OP_QUERY, 89, 59);
        send_random_ops(30, 110, 80);

        // grid capped at its maximum size, last stretch without idling
        apply_geometry(4096, 4096, 300, 200);
        send_random_ops(20, 2600, 1800);
        idle_enable = 1'b0;
        send_random_ops(20, 2600, 1800);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests over %0d grid geometries, %0d results compared",
                 ops_sent, setups, results_checked);
        $display("covered add, remove, query, scan, clear, unused codes and off-grid points");
        if (fail_count == 0 && results_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
